// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the button qualifier design.
// Each macro checks one property on the rising edge of clock and is
// switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDLP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bdlp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BDLP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bdlp assertion failed");

`endif

// ===== hdl/bdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the two-button debounce and long-press unit.
// ----------------------------------------------------------------------------
package bdlp_pkg;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CFG_W      = 16;
   localparam int TIME_W     = 32;

   // Register reset values in milliseconds.
   localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd800;

   // Register index, taken from paddr bit 2.
   typedef enum logic [0:0] {
      CSR_DEBOUNCE   = 1'b0,
      CSR_LONG_PRESS = 1'b1
   } csr_index_type;

   // One tick item as held in the input register.
   typedef struct packed {
      logic [TIME_W-1:0] time_ms;
      logic              engine_level;
      logic              lights_level;
   } tick_type;

   // Current configuration.
   typedef struct packed {
      logic [CFG_W-1:0] debounce_ms;
      logic [CFG_W-1:0] long_press_ms;
   } cfg_type;

   // Engine qualifier status for the tick being processed.
   typedef struct packed {
      logic engine_on;
      logic trip_reset;
      logic engine_stopped;
   } eng_res_type;

endpackage

// ===== hdl/bdlp_req_if.sv =====
// ----------------------------------------------------------------------------
// bdlp_req_if / bdlp_rsp_if
// Valid/ready channels carrying tick items in and qualified flags out.
// ----------------------------------------------------------------------------
interface bdlp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] time_ms;
   logic        engine_level;
   logic        lights_level;

   modport source (output valid, output time_ms, output engine_level,
                   output lights_level, input ready);
   modport sink   (input valid, input time_ms, input engine_level,
                   input lights_level, output ready);
endinterface

interface bdlp_rsp_if;
   logic valid;
   logic ready;
   logic engine_on;
   logic lights_on;
   logic trip_reset;
   logic engine_stopped;

   modport source (output valid, output engine_on, output lights_on,
                   output trip_reset, output engine_stopped, input ready);
   modport sink   (input valid, input engine_on, input lights_on,
                   input trip_reset, input engine_stopped, output ready);
endinterface

// ===== hdl/bdlp_engine.sv =====
// ----------------------------------------------------------------------------
// bdlp_engine
// Engine button qualifier: debounce, long-press hold timing and run flag.
// ----------------------------------------------------------------------------
module bdlp_engine
   import bdlp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  tick_type    tick,
   input  cfg_type     cfg,
   output eng_res_type res
);

   logic [TIME_W-1:0] change_time_ff, change_time_in;
   logic              prev_level_ff, prev_level_in;
   logic [TIME_W-1:0] hold_start_ff, hold_start_in;
   logic              flag_ff, flag_in;

   logic [TIME_W-1:0] hold_eff;
   logic              qualified;
   logic              long_hold;

   // Qualify the level and time the hold for this item.
   always_comb begin
      prev_level_in  = tick.engine_level;
      change_time_in = (tick.engine_level != prev_level_ff) ? tick.time_ms
                                                            : change_time_ff;
      qualified = !tick.engine_level &&
                  ((tick.time_ms - change_time_in) >= {16'b0, cfg.debounce_ms});
      // A stored start of zero means no press is in progress.
      hold_eff  = (hold_start_ff == '0) ? tick.time_ms : hold_start_ff;
      long_hold = (tick.time_ms - hold_eff) >= {16'b0, cfg.long_press_ms};

      flag_in       = flag_ff;
      hold_start_in = hold_start_ff;
      if (qualified) begin
         if (long_hold) begin
            flag_in       = !flag_ff;
            hold_start_in = '0;
         end else begin
            hold_start_in = hold_eff;
         end
      end else if (tick.engine_level) begin
         hold_start_in = '0;
      end

      res.engine_on      = flag_in;
      res.trip_reset     = qualified && long_hold && !flag_ff;
      res.engine_stopped = qualified && long_hold && flag_ff;
   end

   // Button state advances once per processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         change_time_ff <= '0;
         prev_level_ff  <= 1'b1;
         hold_start_ff  <= '0;
         flag_ff        <= 1'b0;
      end else if (step) begin
         change_time_ff <= change_time_in;
         prev_level_ff  <= prev_level_in;
         hold_start_ff  <= hold_start_in;
         flag_ff        <= flag_in;
      end
   end

endmodule

// ===== hdl/bdlp_lights.sv =====
// ----------------------------------------------------------------------------
// bdlp_lights
// Lights button qualifier: one toggle per debounced press.
// ----------------------------------------------------------------------------
module bdlp_lights
   import bdlp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     step,
   input  tick_type tick,
   input  cfg_type  cfg,
   output logic     lights_on
);

   logic [TIME_W-1:0] change_time_ff, change_time_in;
   logic              prev_level_ff, prev_level_in;
   logic              done_ff, done_in;
   logic              flag_ff, flag_in;
   logic              qualified;

   // Toggle once per qualified press; any raw high level re-arms.
   always_comb begin
      prev_level_in  = tick.lights_level;
      change_time_in = (tick.lights_level != prev_level_ff) ? tick.time_ms
                                                            : change_time_ff;
      qualified = !tick.lights_level &&
                  ((tick.time_ms - change_time_in) >= {16'b0, cfg.debounce_ms});
      done_in = done_ff;
      flag_in = flag_ff;
      if (qualified) begin
         if (!done_ff) begin
            done_in = 1'b1;
            flag_in = !flag_ff;
         end
      end else if (tick.lights_level) begin
         done_in = 1'b0;
      end
      lights_on = flag_in;
   end

   // Button state advances once per processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         change_time_ff <= '0;
         prev_level_ff  <= 1'b1;
         done_ff        <= 1'b0;
         flag_ff        <= 1'b0;
      end else if (step) begin
         change_time_ff <= change_time_in;
         prev_level_ff  <= prev_level_in;
         done_ff        <= done_in;
         flag_ff        <= flag_in;
      end
   end

endmodule

// ===== hdl/button_debounce_long_press_toggle_unit.sv =====
// ----------------------------------------------------------------------------
// button_debounce_long_press_toggle_unit
// Two-button qualifier: engine start/stop by long press, lights toggle.
//
//   Channel  Direction  Handshake      Contents
//   req_bus  in         valid/ready    time_ms, engine_level, lights_level
//   rsp_bus  out        valid/ready    engine_on, lights_on, trip_reset,
//                                      engine_stopped
//   csr      in         APB write/read debounce_ms (0x0), long_press_ms (0x4)
//
// One item per cycle sustained while rsp_bus.ready is high. An accepted item
// passes through the input register, then the result register, before its
// result is offered on rsp_bus.
// The button state updates as an item moves from the input register into the
// result register, so the compare-and-toggle logic sets the cycle time.
// A stalled result holds; one more item is taken into the input register.
// Synchronous reset initialises all button state and loads the default timings.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module button_debounce_long_press_toggle_unit
   import bdlp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bdlp_req_if.sink              req_bus,
   bdlp_rsp_if.source            rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type       cfg_ff;
   csr_index_type csr_index;
   logic          csr_write;

   logic          s1_valid_ff, s1_valid_in;
   tick_type      s1_tick_ff;
   logic          s1_move;

   logic          s2_valid_ff, s2_valid_in;
   eng_res_type   s2_eng_ff;
   logic          s2_lights_ff;

   eng_res_type   eng_res;
   logic          lights_next;

   // Configuration registers.
   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      unique case (csr_index)
         CSR_DEBOUNCE:   prdata = {16'b0, cfg_ff.debounce_ms};
         CSR_LONG_PRESS: prdata = {16'b0, cfg_ff.long_press_ms};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= DEBOUNCE_RESET;
         cfg_ff.long_press_ms <= LONG_PRESS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DEBOUNCE:   cfg_ff.debounce_ms   <= pwdata[CFG_W-1:0];
            CSR_LONG_PRESS: cfg_ff.long_press_ms <= pwdata[CFG_W-1:0];
            default:        cfg_ff               <= cfg_ff;
         endcase
      end
   end

   // Pipeline flow control: an item leaves the input register when the
   // result register is empty or being drained.
   assign s1_move       = s1_valid_ff && (!s2_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_move;
   assign s1_valid_in   = req_bus.valid || (s1_valid_ff && !s1_move);
   assign s2_valid_in   = s1_move || (s2_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_bus.ready ? s1_valid_in : s1_valid_ff;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_tick_ff.time_ms      <= req_bus.time_ms;
         s1_tick_ff.engine_level <= req_bus.engine_level;
         s1_tick_ff.lights_level <= req_bus.lights_level;
      end
   end

   // Button qualifiers.
   bdlp_engine u_engine (
      .clock (clock),
      .reset (reset),
      .step  (s1_move),
      .tick  (s1_tick_ff),
      .cfg   (cfg_ff),
      .res   (eng_res)
   );

   bdlp_lights u_lights (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_move),
      .tick      (s1_tick_ff),
      .cfg       (cfg_ff),
      .lights_on (lights_next)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_eng_ff    <= eng_res;
         s2_lights_ff <= lights_next;
      end
   end

   assign rsp_bus.valid          = s2_valid_ff;
   assign rsp_bus.engine_on      = s2_eng_ff.engine_on;
   assign rsp_bus.lights_on      = s2_lights_ff;
   assign rsp_bus.trip_reset     = s2_eng_ff.trip_reset;
   assign rsp_bus.engine_stopped = s2_eng_ff.engine_stopped;

   // A start and a stop never come from the same tick, and agree with the flag.
   `BDLP_ASSERT_SAME(a_start_means_on, s2_valid_ff && s2_eng_ff.trip_reset,
                     s2_eng_ff.engine_on && !s2_eng_ff.engine_stopped)
   `BDLP_ASSERT_SAME(a_stop_means_off, s2_valid_ff && s2_eng_ff.engine_stopped,
                     !s2_eng_ff.engine_on)
   // A held result blocks the input register from advancing.
   `BDLP_ASSERT_SAME(a_stall_blocks, s2_valid_ff && !rsp_bus.ready, !s1_move)
   // An accepted item is present in the input register next cycle.
   `BDLP_ASSERT_NEXT(a_accept_fills, req_bus.valid && req_bus.ready, s1_valid_ff)

endmodule
